>>> rtl/core/dlr_pkg.sv
// shared types, codes and constants of the dimmer level ramp
package dlr_pkg;

   localparam int LEVEL_W   = 14;
   localparam int FUNC_W    = 3;
   localparam int MODE_W    = 3;
   localparam int PCT_W     = 7;
   localparam int SEC_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   localparam int DEF_FORCED_PERIOD    = 20;
   localparam int DEF_TICKS_PER_SECOND = 1000;

   localparam logic [LEVEL_W-1:0] FULL_SCALE    = LEVEL_W'(10000);
   localparam logic [LEVEL_W-1:0] DUTY_RESET    = LEVEL_W'(3000);
   localparam logic [PCT_W-1:0]   PCT_MAX       = PCT_W'(100);
   localparam logic [LEVEL_W-1:0] PCT_SCALE     = LEVEL_W'(100);
   localparam logic [PCT_W-1:0]   HIGH_PCT_RESET = PCT_W'(100);

   localparam logic [LEVEL_W-1:0] MOTION_UP   = LEVEL_W'(50);
   localparam logic [LEVEL_W-1:0] MOTION_DOWN = LEVEL_W'(3);
   localparam logic [LEVEL_W-1:0] VOLUME_STEP = LEVEL_W'(100);
   localparam logic [LEVEL_W-1:0] FINE_STEP   = LEVEL_W'(1);

   // operating modes
   localparam logic [MODE_W-1:0] MODE_MOTION   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_VOLUME   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TEST     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DAYLIGHT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd4;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MOTION   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FORCE    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 3'd4;

   // register indexes
   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_LOW_PCT  = 2'd1;
   localparam logic [1:0] REG_HIGH_PCT = 2'd2;
   localparam logic [1:0] REG_HOLD_SEC = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PCT_W-1:0]  low_percent;
      logic [PCT_W-1:0]  high_percent;
      logic [SEC_W-1:0]  hold_seconds;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] current_level;
      logic [LEVEL_W-1:0] drive_duty;
      logic               duty_written;
      logic [LEVEL_W-1:0] target_level;
   } res_type;

   function automatic logic [LEVEL_W-1:0] pct_to_level(input logic [PCT_W-1:0] pct);
      logic [PCT_W-1:0] p_sat;
      p_sat = (pct > PCT_MAX) ? PCT_MAX : pct;
      return LEVEL_W'(LEVEL_W'(p_sat) * PCT_SCALE);
   endfunction

endpackage

>>> rtl/core/dlr_csr.sv
// configuration registers behind the apb-style port
module dlr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dlr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dlr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dlr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output dlr_pkg::cfg_type                  cfg
);

   dlr_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       reg_index;
   logic             write_en;

   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            dlr_pkg::REG_MODE:     cfg_in.mode = csr_pwdata[dlr_pkg::MODE_W-1:0];
            dlr_pkg::REG_LOW_PCT:  cfg_in.low_percent = csr_pwdata[dlr_pkg::PCT_W-1:0];
            dlr_pkg::REG_HIGH_PCT: cfg_in.high_percent = csr_pwdata[dlr_pkg::PCT_W-1:0];
            dlr_pkg::REG_HOLD_SEC: cfg_in.hold_seconds = csr_pwdata[dlr_pkg::SEC_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         dlr_pkg::REG_MODE:     csr_prdata = dlr_pkg::CSR_DATA_W'(cfg_ff.mode);
         dlr_pkg::REG_LOW_PCT:  csr_prdata = dlr_pkg::CSR_DATA_W'(cfg_ff.low_percent);
         dlr_pkg::REG_HIGH_PCT: csr_prdata = dlr_pkg::CSR_DATA_W'(cfg_ff.high_percent);
         dlr_pkg::REG_HOLD_SEC: csr_prdata = dlr_pkg::CSR_DATA_W'(cfg_ff.hold_seconds);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= dlr_pkg::MODE_MOTION;
         cfg_ff.low_percent  <= '0;
         cfg_ff.high_percent <= dlr_pkg::HIGH_PCT_RESET;
         cfg_ff.hold_seconds <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/dlr_step.sv
// ramp state and the next-state logic for one request
module dlr_step #(
   parameter int FORCED_PERIOD    = dlr_pkg::DEF_FORCED_PERIOD,
   parameter int TICKS_PER_SECOND = dlr_pkg::DEF_TICKS_PER_SECOND
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [dlr_pkg::FUNC_W-1:0]        func,
   input  logic [dlr_pkg::LEVEL_W-1:0]       level,
   input  dlr_pkg::cfg_type                  cfg,
   output dlr_pkg::res_type                  res
);

   localparam int LW     = dlr_pkg::LEVEL_W;
   localparam int TICK_W = (FORCED_PERIOD > 1) ? $clog2(FORCED_PERIOD) : 1;
   localparam int HOLD_W = $clog2(255 * TICKS_PER_SECOND + 1);

   logic [LW-1:0]     level_ff, level_in;
   logic [LW-1:0]     target_ff, target_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              forced_ff, forced_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [LW-1:0]     duty_ff, duty_in;
   logic              written;

   logic [LW-1:0]     lvl_sat;
   logic [LW-1:0]     step_up, step_down;
   logic              has_ramp;
   logic              hold_expired;
   logic [LW-1:0]     ramp_target;
   logic [LW-1:0]     ramp_level;
   logic              moving;
   logic [TICK_W:0]   tick_inc;
   logic [TICK_W-1:0] tick_next;

   assign lvl_sat = (level > dlr_pkg::FULL_SCALE) ? dlr_pkg::FULL_SCALE : level;

   always_comb begin
      step_up   = dlr_pkg::FINE_STEP;
      step_down = dlr_pkg::FINE_STEP;
      has_ramp  = 1'b1;
      case (cfg.mode)
         dlr_pkg::MODE_MOTION: begin
            step_up   = dlr_pkg::MOTION_UP;
            step_down = dlr_pkg::MOTION_DOWN;
         end
         dlr_pkg::MODE_VOLUME: begin
            step_up   = dlr_pkg::VOLUME_STEP;
            step_down = dlr_pkg::VOLUME_STEP;
         end
         dlr_pkg::MODE_TEST, dlr_pkg::MODE_DAYLIGHT: begin
            step_up   = dlr_pkg::FINE_STEP;
            step_down = dlr_pkg::FINE_STEP;
         end
         default: has_ramp = 1'b0;
      endcase
   end

   // hold countdown decides the target the ramp heads for
   assign hold_expired = (cfg.mode == dlr_pkg::MODE_MOTION) && (hold_ff == '0);
   assign ramp_target  = hold_expired ? dlr_pkg::pct_to_level(cfg.low_percent) : target_ff;

   always_comb begin
      if (ramp_target >= level_ff) begin
         if (level_ff + step_up >= ramp_target) begin
            ramp_level = ramp_target;
            moving     = 1'b0;
         end else begin
            ramp_level = level_ff + step_up;
            moving     = 1'b1;
         end
      end else begin
         if (level_ff <= ramp_target + step_down) begin
            ramp_level = ramp_target;
            moving     = 1'b0;
         end else begin
            ramp_level = level_ff - step_down;
            moving     = 1'b1;
         end
      end
   end

   assign tick_inc  = {1'b0, tick_ff} + (TICK_W+1)'(1);
   assign tick_next = (tick_inc >= (TICK_W+1)'(FORCED_PERIOD)) ? '0 : tick_inc[TICK_W-1:0];

   always_comb begin
      level_in  = level_ff;
      target_in = target_ff;
      hold_in   = hold_ff;
      forced_in = forced_ff;
      tick_in   = tick_ff;
      duty_in   = duty_ff;
      written   = 1'b0;
      case (func)
         dlr_pkg::FUNC_TICK: begin
            if (forced_ff) begin
               tick_in = tick_next;
               if (tick_ff == '0) begin
                  duty_in = target_ff;
                  written = 1'b1;
               end
            end else if (has_ramp) begin
               if (cfg.mode == dlr_pkg::MODE_MOTION) begin
                  if (hold_expired) begin
                     target_in = ramp_target;
                  end else begin
                     hold_in = hold_ff - HOLD_W'(1);
                  end
               end
               level_in = ramp_level;
               if (moving) begin
                  duty_in = dlr_pkg::FULL_SCALE - ramp_level;
                  written = 1'b1;
               end
            end
         end
         dlr_pkg::FUNC_MOTION: begin
            target_in = dlr_pkg::pct_to_level(cfg.high_percent);
            hold_in   = HOLD_W'(HOLD_W'(cfg.hold_seconds) * HOLD_W'(TICKS_PER_SECOND));
         end
         dlr_pkg::FUNC_SET: target_in = lvl_sat;
         dlr_pkg::FUNC_FORCE: begin
            forced_in = 1'b1;
            target_in = lvl_sat;
         end
         dlr_pkg::FUNC_RELEASE: forced_in = 1'b0;
         default: ;
      endcase
   end

   assign res.current_level = level_in;
   assign res.drive_duty    = duty_in;
   assign res.duty_written  = written;
   assign res.target_level  = target_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         target_ff <= '0;
         hold_ff   <= '0;
         forced_ff <= 1'b0;
         tick_ff   <= '0;
         duty_ff   <= dlr_pkg::DUTY_RESET;
      end else if (step_en) begin
         level_ff  <= level_in;
         target_ff <= target_in;
         hold_ff   <= hold_in;
         forced_ff <= forced_in;
         tick_ff   <= tick_in;
         duty_ff   <= duty_in;
      end
   end

endmodule

>>> rtl/core/dimmer_level_ramp_top.sv
// top level of the dimmer level ramp: request and response registers around the step logic
//
// Each request is one item: a millisecond tick, a motion trigger, a set-target,
// a force-level or a release-force, selected by req_tuser, with the level in
// req_tdata. Every request yields exactly one response carrying the ramped
// level, the duty held on the pwm output, a flag telling whether this request
// wrote the duty, and the current target.
// A request is registered on acceptance and processed from the request register once
// the response register can advance; at the end of that cycle the ramp state and the
// response register are loaded. One request is taken per cycle as long as the
// response side keeps up; the single step of ramp, hold and forced-tick logic sets
// that rate.
// When a response waits and rsp_tready is low the response register holds; the
// request register still takes one more request, after which req_tready falls
// until the response is taken.
// Reset clears the level, target, hold count and forced state, sets the held
// duty to 3000 and loads the register defaults (high percent 100, others 0).
// The user must write registers over the csr_ port only while no request is in flight; not enforced.
module dimmer_level_ramp_top #(
   parameter int FORCED_PERIOD    = dlr_pkg::DEF_FORCED_PERIOD,
   parameter int TICKS_PER_SECOND = dlr_pkg::DEF_TICKS_PER_SECOND
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dlr_pkg::REQ_DATA_W-1:0]    req_tdata,  // level[13:0], zeros
   input  logic [dlr_pkg::FUNC_W-1:0]        req_tuser,  // func[2:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dlr_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // current_level, drive_duty,
                                                         // target_level, zeros
   output logic                              rsp_tuser,  // duty_written
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dlr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dlr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dlr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int LW  = dlr_pkg::LEVEL_W;
   localparam int PAD = dlr_pkg::RSP_DATA_W - 3 * LW;

   dlr_pkg::cfg_type cfg;
   dlr_pkg::res_type res;

   logic              req_valid_ff, req_valid_in;
   logic [dlr_pkg::FUNC_W-1:0] req_func_ff, req_func_in;
   logic [LW-1:0]     req_level_ff, req_level_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dlr_pkg::res_type  rsp_ff, rsp_in;

   logic              req_take;
   logic              advance;
   logic              step_en;

   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign step_en    = req_valid_ff & advance;
   assign req_tready = ~req_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_func_in  = req_func_ff;
      req_level_in = req_level_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
         req_func_in  = req_tuser;
         req_level_in = req_tdata[LW-1:0];
      end else if (step_en) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
         if (step_en) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_func_ff  <= req_func_in;
      req_level_ff <= req_level_in;
      rsp_ff       <= rsp_in;
   end

   dlr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dlr_step #(
      .FORCED_PERIOD    (FORCED_PERIOD),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .func    (req_func_ff),
      .level   (req_level_ff),
      .cfg     (cfg),
      .res     (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, rsp_ff.target_level, rsp_ff.drive_duty,
                        rsp_ff.current_level};
   assign rsp_tuser  = rsp_ff.duty_written;

endmodule

>>> test/ramp_response_checker.sv
// response checker for the dimmer level ramp: predicts each response and compares it
module ramp_response_checker
   import dlr_pkg::*;
#(
   parameter int FORCED_PERIOD    = DEF_FORCED_PERIOD,
   parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    pending,
   output int                    failures
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [MODE_W-1:0]  cfg_mode;
   logic [PCT_W-1:0]   cfg_low;
   logic [PCT_W-1:0]   cfg_high;
   logic [SEC_W-1:0]   cfg_hold;

   logic [LEVEL_W-1:0] level_now;
   logic [LEVEL_W-1:0] target;
   logic [17:0]        hold_left;
   logic               forced;
   int                 forced_phase;
   logic [LEVEL_W-1:0] duty;

   res_type expected_responses[$];

   function automatic logic [LEVEL_W-1:0] percent_level(input logic [PCT_W-1:0] p);
      return (p > PCT_W'(100)) ? FULL_SCALE : LEVEL_W'(p) * LEVEL_W'(100);
   endfunction

   // one step toward the target, true while still moving
   function automatic bit slew(input int up, input int down);
      int lv;
      int tg;
      lv = level_now;
      tg = target;
      if (tg >= lv) begin
         if (lv + up >= tg) begin
            level_now = target;
            return 1'b0;
         end
         level_now = LEVEL_W'(lv + up);
         return 1'b1;
      end
      if (lv <= tg + down) begin
         level_now = target;
         return 1'b0;
      end
      level_now = LEVEL_W'(lv - down);
      return 1'b1;
   endfunction

   function automatic bit run_tick();
      bit fire;
      bit moving;
      if (forced) begin
         fire = (forced_phase == 0);
         forced_phase = (forced_phase + 1 >= FORCED_PERIOD) ? 0 : forced_phase + 1;
         if (fire) duty = target;
         return fire;
      end
      case (cfg_mode)
         MODE_MOTION: begin
            if (hold_left != 0) hold_left = hold_left - 1'b1;
            else target = percent_level(cfg_low);
            moving = slew(MOTION_UP, MOTION_DOWN);
         end
         MODE_VOLUME: moving = slew(VOLUME_STEP, VOLUME_STEP);
         MODE_TEST, MODE_DAYLIGHT: moving = slew(FINE_STEP, FINE_STEP);
         default: moving = 1'b0;
      endcase
      if (moving) duty = FULL_SCALE - level_now;
      return moving;
   endfunction

   function automatic res_type predict_response(input logic [FUNC_W-1:0] fn,
                                                input logic [LEVEL_W-1:0] raw);
      res_type r;
      logic [LEVEL_W-1:0] lvl;
      bit wr;
      lvl = (raw > FULL_SCALE) ? FULL_SCALE : raw;
      wr = 1'b0;
      case (fn)
         FUNC_TICK: wr = run_tick();
         FUNC_MOTION: begin
            target = percent_level(cfg_high);
            hold_left = 18'(cfg_hold * TICKS_PER_SECOND);
         end
         FUNC_SET: target = lvl;
         FUNC_FORCE: begin
            forced = 1'b1;
            target = lvl;
         end
         FUNC_RELEASE: forced = 1'b0;
         default: ;
      endcase
      r.current_level = level_now;
      r.drive_duty = duty;
      r.duty_written = wr;
      r.target_level = target;
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         failures++;
         if (failures <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      res_type got;
      res_type want;
      if (reset) begin
         cfg_mode = MODE_MOTION;
         cfg_low = '0;
         cfg_high = HIGH_PCT_RESET;
         cfg_hold = '0;
         level_now = '0;
         target = '0;
         hold_left = '0;
         forced = 1'b0;
         forced_phase = 0;
         duty = DUTY_RESET;
         expected_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.current_level = rsp_tdata[LEVEL_W-1:0];
            got.drive_duty = rsp_tdata[2*LEVEL_W-1:LEVEL_W];
            got.target_level = rsp_tdata[3*LEVEL_W-1:2*LEVEL_W];
            got.duty_written = rsp_tuser;
            if (expected_responses.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("response with no request outstanding: level %0d duty %0d",
                           got.current_level, got.drive_duty);
            end else begin
               want = expected_responses.pop_front();
               check_field("current_level", want.current_level, got.current_level);
               check_field("drive_duty", want.drive_duty, got.drive_duty);
               check_field("duty_written", want.duty_written, got.duty_written);
               check_field("target_level", want.target_level, got.target_level);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_MODE:     cfg_mode = csr_pwdata[MODE_W-1:0];
               REG_LOW_PCT:  cfg_low = csr_pwdata[PCT_W-1:0];
               REG_HIGH_PCT: cfg_high = csr_pwdata[PCT_W-1:0];
               REG_HOLD_SEC: cfg_hold = csr_pwdata[SEC_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_responses.push_back(predict_response(req_tuser, req_tdata[LEVEL_W-1:0]));
      end
      pending = expected_responses.size();
   end

endmodule

>>> test/testbench.sv
// top of the dimmer level ramp testbench: clock, reset, request and register stimulus, verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dlr_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LAST  = 3'd7;
   localparam logic [MODE_W-1:0] MODE_UNKNOWN_LAST  = 3'd7;
   localparam logic [LEVEL_W-1:0] LEVEL_ALL_ONES    = '1;
   localparam int STALL_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          pending;
   int          failures;
   logic        steady = 1'b0;
   int unsigned stall_left = 0;
   int          idle_cycles = 0;

   dimmer_level_ramp_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ramp_response_checker response_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .failures    (failures)
   );

   always #1 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [FUNC_W-1:0] random_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return FUNC_TICK;
      if (r < 65) return FUNC_MOTION;
      if (r < 80) return FUNC_SET;
      if (r < 86) return FUNC_FORCE;
      if (r < 96) return FUNC_RELEASE;
      return FUNC_W'($urandom_range(FUNC_UNKNOWN_FIRST, FUNC_UNKNOWN_LAST));
   endfunction

   function automatic logic [LEVEL_W-1:0] random_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return FULL_SCALE;
      if (r < 15) return LEVEL_W'($urandom_range(FULL_SCALE + 1, LEVEL_ALL_ONES));
      if (r < 20) return LEVEL_ALL_ONES;
      return LEVEL_W'($urandom_range(0, FULL_SCALE));
   endfunction

   function automatic logic [PCT_W-1:0] random_percent();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return PCT_MAX;
      if (r == 2) return PCT_W'($urandom_range(PCT_MAX + 1, 127));
      return PCT_W'($urandom_range(0, PCT_MAX));
   endfunction

   function automatic logic [SEC_W-1:0] random_hold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return '0;
      if (r < 85) return SEC_W'(1);
      if (r < 95) return SEC_W'(2);
      return SEC_W'($urandom_range(3, 255));
   endfunction

   function automatic logic [MODE_W-1:0] random_mode();
      if ($urandom_range(0, 99) < 85)
         return MODE_W'($urandom_range(MODE_MOTION, MODE_DAYLIGHT));
      return MODE_W'($urandom_range(MODE_IDLE, MODE_UNKNOWN_LAST));
   endfunction

   // entered and left at a falling edge, valid stays high for a back-to-back request
   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [LEVEL_W-1:0] lvl);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = fn;
      req_tdata = REQ_DATA_W'(lvl);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic load_settings(input logic [MODE_W-1:0] m, input logic [PCT_W-1:0] lo,
                                input logic [PCT_W-1:0] hi, input logic [SEC_W-1:0] hold);
      write_reg(REG_MODE, CSR_DATA_W'(m));
      write_reg(REG_LOW_PCT, CSR_DATA_W'(lo));
      write_reg(REG_HIGH_PCT, CSR_DATA_W'(hi));
      write_reg(REG_HOLD_SEC, CSR_DATA_W'(hold));
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready = 1'b1;
         if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("dimmer_level_ramp_top test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      int r;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      load_settings(MODE_MOTION, 7'd5, 7'd127, 8'd1);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_MOTION, '0);
      send_request(FUNC_TICK, LEVEL_ALL_ONES);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_SET, LEVEL_ALL_ONES);
      send_request(FUNC_SET, FULL_SCALE + 1'b1);
      send_request(FUNC_SET, '0);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_SET, FULL_SCALE);
      send_request(FUNC_FORCE, 14'd7000);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_MOTION, 14'd5);
      send_request(FUNC_RELEASE, '0);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_UNKNOWN_FIRST, 14'd1234);
      send_request(FUNC_UNKNOWN_LAST, LEVEL_ALL_ONES);
      send_request(FUNC_SET, 14'd60);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_FORCE, LEVEL_ALL_ONES);
      send_request(FUNC_TICK, '0);
      send_request(FUNC_RELEASE, '0);
      send_request(FUNC_SET, 14'd9999);

      // motion hold long enough to run out
      drain_responses();
      load_settings(MODE_MOTION, 7'd30, 7'd90, 8'd1);
      send_request(FUNC_MOTION, random_level());
      for (n = 0; n < 1150; n++) begin
         r = $urandom_range(0, 99);
         if (r < 92) send_request(FUNC_TICK, random_level());
         else if (r < 97) send_request(FUNC_SET, random_level());
         else send_request(FUNC_RELEASE, random_level());
      end

      for (phase = 0; phase < 6; phase++) begin
         drain_responses();
         case (phase)
            0: load_settings(MODE_DAYLIGHT, 7'd127, 7'd127, 8'd255);
            1: load_settings(MODE_UNKNOWN_LAST, 7'd100, 7'd0, 8'd0);
            2: load_settings(MODE_VOLUME, random_percent(), random_percent(), random_hold());
            3: load_settings(MODE_TEST, random_percent(), random_percent(), random_hold());
            4: load_settings(MODE_IDLE, random_percent(), random_percent(), random_hold());
            default: load_settings(random_mode(), random_percent(), random_percent(),
                                   random_hold());
         endcase
         steady = (phase == 2);
         for (n = 0; n < 50; n++) begin
            if (n == 25) drain_responses();
            send_request(random_func(), random_level());
         end
      end

      steady = 1'b0;
      drain_responses();
      repeat (6) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("dimmer_level_ramp_top test passed");
      else
         $display("dimmer_level_ramp_top test failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/dlr_pkg.sv
rtl/core/dlr_csr.sv
rtl/core/dlr_step.sv
rtl/core/dimmer_level_ramp_top.sv
test/ramp_response_checker.sv
test/testbench.sv
